>>> hdl/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg: shared constants for the positional list block
// Capacity, derived widths, operation codes and status codes.
// ----------------------------------------------------------------------------
package pli_pkg;

    // list capacity and derived widths
    localparam int CAPACITY = 32;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 8;
    localparam int POS_W    = 8;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    // operation codes (s_tuser)
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_PRINT  = 2'd2;

    // status codes (m_tuser[2:1])
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;
    localparam logic [1:0] STAT_FULL  = 2'd3;

endpackage

>>> hdl/pli_ram.sv
// ----------------------------------------------------------------------------
// pli_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pli_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                      aclk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> hdl/positional_list_insert_delete.sv
// Sequence: insert shifts the entries from position up one, then writes the item;
//   delete captures the entry, shifts later ones down; results go via the output
//   register; print streams one entry per cycle while m_tready is high.
// Throughput: one item at a time; the entry memory's single read and write port
//   moves one entry per cycle.
// Reset: aresetn (synchronous) empties the list at once; the entry memory is not
//   cleared, no sweep is needed, and s_tready is high in the next cycle.
// ----------------------------------------------------------------------------
// positional_list_insert_delete: ordered byte list with insert/delete by index
// Entries live in one RAM; insert and delete shift entries one per cycle.
// ----------------------------------------------------------------------------
module positional_list_insert_delete (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] item_value, [15:8] position
    input  logic [1:0]  s_tuser,   // [1:0] operation
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_value
    output logic [2:0]  m_tuser,   // [0] has_value, [2:1] status
    output logic        m_tlast
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SHIFT,
        S_INS_PUT,
        S_DEL_FIRST,
        S_DEL_SHIFT,
        S_PRINT,
        S_EMIT
    } state_t;

    state_t                      state_reg, state_next;
    logic [pli_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [pli_pkg::ADDR_W-1:0]  src_reg, src_next;
    logic [pli_pkg::ADDR_W-1:0]  put_reg, put_next;
    logic [pli_pkg::VAL_W-1:0]   val_reg, val_next;
    logic [pli_pkg::VAL_W-1:0]   res_value_reg, res_value_next;
    logic                        res_has_reg, res_has_next;
    logic [1:0]                  res_status_reg, res_status_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [7:0]                  m_tdata_reg, m_tdata_next;
    logic [2:0]                  m_tuser_reg, m_tuser_next;
    logic                        m_tlast_reg, m_tlast_next;

    logic                        ram_we;
    logic [pli_pkg::ADDR_W-1:0]  ram_waddr;
    logic [pli_pkg::VAL_W-1:0]   ram_wdata;
    logic [pli_pkg::VAL_W-1:0]   ram_rdata;

    logic                        out_free;
    logic [pli_pkg::CNT_W-1:0]   count_m1;
    logic [pli_pkg::ADDR_W-1:0]  last_idx;
    logic [pli_pkg::CMP_W-1:0]   pos_ext;
    logic [pli_pkg::CMP_W-1:0]   cnt_ext;

    // entry store; read address is the next source index so data lines up
    pli_ram #(
        .WIDTH (pli_pkg::VAL_W),
        .DEPTH (pli_pkg::CAPACITY)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (src_next),
        .rd_data (ram_rdata)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign count_m1 = count_reg - pli_pkg::CNT_W'(1);
    assign last_idx = count_m1[pli_pkg::ADDR_W-1:0];
    assign pos_ext  = pli_pkg::CMP_W'(s_tdata[15:8]);
    assign cnt_ext  = pli_pkg::CMP_W'(count_reg);

    // sequencer next-state logic
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        src_next        = src_reg;
        put_next        = put_reg;
        val_next        = val_reg;
        res_value_next  = res_value_reg;
        res_has_next    = res_has_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        m_tlast_next    = m_tlast_reg;
        ram_we          = 1'b0;
        ram_waddr       = src_reg + pli_pkg::ADDR_W'(1);
        ram_wdata       = ram_rdata;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    val_next        = s_tdata[7:0];
                    put_next        = s_tdata[8 +: pli_pkg::ADDR_W];
                    res_value_next  = '0;
                    res_has_next    = 1'b0;
                    res_status_next = pli_pkg::STAT_OK;
                    state_next      = S_EMIT;
                    case (s_tuser)
                        pli_pkg::OP_INSERT: begin
                            if (count_reg == '0) begin
                                put_next   = '0;
                                state_next = S_INS_PUT;
                            end else if (count_reg >= pli_pkg::CNT_W'(pli_pkg::CAPACITY)) begin
                                res_status_next = pli_pkg::STAT_FULL;
                            end else if (pos_ext > cnt_ext) begin
                                res_status_next = pli_pkg::STAT_RANGE;
                            end else if (pos_ext == cnt_ext) begin
                                state_next = S_INS_PUT;
                            end else begin
                                src_next   = last_idx;
                                state_next = S_INS_SHIFT;
                            end
                        end
                        pli_pkg::OP_DELETE: begin
                            if (count_reg == '0) begin
                                res_status_next = pli_pkg::STAT_EMPTY;
                            end else if (pos_ext >= cnt_ext) begin
                                res_status_next = pli_pkg::STAT_RANGE;
                            end else begin
                                src_next   = s_tdata[8 +: pli_pkg::ADDR_W];
                                state_next = S_DEL_FIRST;
                            end
                        end
                        pli_pkg::OP_PRINT: begin
                            if (count_reg != '0) begin
                                src_next   = '0;
                                state_next = S_PRINT;
                            end
                        end
                        default: begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end

            // move entry src up by one, walking down to the insert point
            S_INS_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = src_reg + pli_pkg::ADDR_W'(1);
                if (src_reg == put_reg) begin
                    state_next = S_INS_PUT;
                end else begin
                    src_next = src_reg - pli_pkg::ADDR_W'(1);
                end
            end

            S_INS_PUT: begin
                ram_we     = 1'b1;
                ram_waddr  = put_reg;
                ram_wdata  = val_reg;
                count_next = count_reg + pli_pkg::CNT_W'(1);
                state_next = S_EMIT;
            end

            // capture the removed entry
            S_DEL_FIRST: begin
                res_value_next = ram_rdata;
                res_has_next   = 1'b1;
                if (src_reg == last_idx) begin
                    count_next = count_m1;
                    state_next = S_EMIT;
                end else begin
                    src_next   = src_reg + pli_pkg::ADDR_W'(1);
                    state_next = S_DEL_SHIFT;
                end
            end

            // move entry src down by one, walking up to the tail
            S_DEL_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = src_reg - pli_pkg::ADDR_W'(1);
                if (src_reg == last_idx) begin
                    count_next = count_m1;
                    state_next = S_EMIT;
                end else begin
                    src_next = src_reg + pli_pkg::ADDR_W'(1);
                end
            end

            // stream entries straight into the output register
            S_PRINT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = ram_rdata;
                    m_tuser_next  = {pli_pkg::STAT_OK, 1'b1};
                    m_tlast_next  = (src_reg == last_idx);
                    if (src_reg == last_idx) begin
                        state_next = S_IDLE;
                    end else begin
                        src_next = src_reg + pli_pkg::ADDR_W'(1);
                    end
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_value_reg;
                    m_tuser_next  = {res_status_reg, res_has_reg};
                    m_tlast_next  = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        src_reg        <= src_next;
        put_reg        <= put_next;
        val_reg        <= val_next;
        res_value_reg  <= res_value_next;
        res_has_reg    <= res_has_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
        m_tlast_reg    <= m_tlast_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

>>> hdl/pli_checker.sv
// ----------------------------------------------------------------------------
// pli_checker: port-level checks for the positional list block
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module pli_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result transfer dropped while stalled");

    // the block is ready right after reset
    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("not ready after reset");

    // one item at a time: an accepted item closes the input
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is at work");

    // results without an entry carry a zero byte
    a_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
        else $error("nonzero value without has_value");

    // an error status ends the item and carries no entry
    a_error_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2:1] != pli_pkg::STAT_OK |-> m_tlast && !m_tuser[0])
        else $error("error result not single or carries a value");

endmodule

bind positional_list_insert_delete pli_checker u_pli_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> tb/list_order_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// list_order_checker: prediction and compare for the positional list block
// Watches the input and result channels. It keeps its own copy of the list,
// works out the results of every accepted input transfer, and compares each
// result transfer field by field with the oldest one still due.
// ----------------------------------------------------------------------------
module list_order_checker (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] item_value, [15:8] position
    input  logic [1:0]  s_tuser,   // [1:0] operation
    // result channel
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [7:0] out_value
    input  logic [2:0]  m_tuser,   // [0] has_value, [2:1] status
    input  logic        m_tlast,
    // status toward the testbench top
    output int          fail_count,
    output int          pending,
    output int          list_length
);

    import pli_pkg::*;

    typedef struct packed {
        logic [VAL_W-1:0] out_value;
        logic             has_value;
        logic [1:0]       status;
        logic             last;
    } list_output_t;

    // shadow copy of the list
    logic [VAL_W-1:0] shadow_entries [CAPACITY];
    int               shadow_len;

    // results still owed by the block, oldest first
    list_output_t     outputs_due [$];

    initial begin
        fail_count  = 0;
        pending     = 0;
        list_length = 0;
        shadow_len  = 0;
    end

    task automatic owe_output(input logic [VAL_W-1:0] value, input logic has,
                              input logic [1:0] status, input logic last);
        list_output_t r;
        r.out_value = value;
        r.has_value = has;
        r.status    = status;
        r.last      = last;
        outputs_due.push_back(r);
    endtask

    // update the shadow list for one accepted transfer and owe its results
    task automatic apply_list_op(input logic [1:0] op, input logic [VAL_W-1:0] value,
                                 input logic [POS_W-1:0] position);
        int pos;
        int i;
        pos = int'(position);
        case (op)
            OP_INSERT: begin
                if (shadow_len == 0) begin
                    // empty list: position is ignored, entry lands in slot 0
                    shadow_entries[0] = value;
                    shadow_len = 1;
                    owe_output('0, 1'b0, STAT_OK, 1'b1);
                end else if (shadow_len >= CAPACITY) begin
                    owe_output('0, 1'b0, STAT_FULL, 1'b1);
                end else if (pos > shadow_len) begin
                    owe_output('0, 1'b0, STAT_RANGE, 1'b1);
                end else begin
                    for (i = shadow_len; i > pos; i--)
                        shadow_entries[ADDR_W'(i)] = shadow_entries[ADDR_W'(i - 1)];
                    shadow_entries[ADDR_W'(pos)] = value;
                    shadow_len++;
                    owe_output('0, 1'b0, STAT_OK, 1'b1);
                end
            end
            OP_DELETE: begin
                if (shadow_len == 0) begin
                    owe_output('0, 1'b0, STAT_EMPTY, 1'b1);
                end else if (pos >= shadow_len) begin
                    owe_output('0, 1'b0, STAT_RANGE, 1'b1);
                end else begin
                    owe_output(shadow_entries[ADDR_W'(pos)], 1'b1, STAT_OK, 1'b1);
                    for (i = pos; i + 1 < shadow_len; i++)
                        shadow_entries[ADDR_W'(i)] = shadow_entries[ADDR_W'(i + 1)];
                    shadow_len--;
                end
            end
            OP_PRINT: begin
                if (shadow_len == 0) begin
                    owe_output('0, 1'b0, STAT_OK, 1'b1);
                end else begin
                    for (i = 0; i < shadow_len; i++)
                        owe_output(shadow_entries[ADDR_W'(i)], 1'b1, STAT_OK,
                                   i + 1 == shadow_len);
                end
            end
            default: begin
                // unused code: list untouched, one bare result
                owe_output('0, 1'b0, STAT_OK, 1'b1);
            end
        endcase
    endtask

    task automatic check_field(input string name, input int expected_v, input int actual_v);
        if (expected_v != actual_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, expected_v, actual_v);
            fail_count++;
        end
    endtask

    // results are compared before the same edge's input is predicted: an
    // item's results never leave in the cycle it is accepted
    always @(posedge aclk) begin : track
        list_output_t exp_r;
        if (!aresetn) begin
            shadow_len = 0;
            outputs_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (outputs_due.size() == 0) begin
                    $error("result transfer with nothing due: out_value %0d, tuser %0d",
                           m_tdata, m_tuser);
                    fail_count++;
                end else begin
                    exp_r = outputs_due.pop_front();
                    check_field("out_value", int'(exp_r.out_value), int'(m_tdata));
                    check_field("has_value", int'(exp_r.has_value), int'(m_tuser[0]));
                    check_field("status", int'(exp_r.status), int'(m_tuser[2:1]));
                    check_field("last", int'(exp_r.last), int'(m_tlast));
                end
            end
            if (s_tvalid && s_tready)
                apply_list_op(s_tuser, s_tdata[7:0], s_tdata[15:8]);
        end
        pending     = outputs_due.size();
        list_length = shadow_len;
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for positional_list_insert_delete
// A directed pass covers empty, out-of-range and ignored-position cases and
// the unused operation code; random rounds then fill the list to capacity,
// drain it to empty and mix operations, with random idle bursts on both
// channels. The checker beside the block does all the comparing.
// ----------------------------------------------------------------------------
module testbench;

    import pli_pkg::*;

    // code the block does not define; must give one bare result
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_WAIT  = 2 * CAPACITY + 8;
    localparam int ROUNDS      = 9;
    localparam int ROUND_ITEMS = 46;

    // random round flavors
    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [7:0] item_value, [15:8] position
    logic [1:0]  s_tuser;   // [1:0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;   // [7:0] out_value
    logic [2:0]  m_tuser;   // [0] has_value, [2:1] status
    logic        m_tlast;

    int fail_count;
    int pending;
    int list_length;
    int cycle_count = 0;
    int stall_left  = 0;
    bit idling_on   = 1'b0;

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    positional_list_insert_delete i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    list_order_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .pending     (pending),
        .list_length (list_length)
    );

    // result-side back-pressure: random bursts with m_tready held low
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            m_tready   = 1'b0;
            stall_left = $urandom_range(0, 3);
        end else begin
            m_tready = 1'b1;
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // present one transfer, starting at a falling edge; returns after acceptance
    task automatic send_item(input logic [1:0] op, input logic [7:0] value,
                             input logic [7:0] position);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {position, value};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_directed(input logic [1:0] op, input logic [7:0] value,
                                 input logic [7:0] position);
        @(negedge aclk);
        send_item(op, value, position);
    endtask

    // one random transfer, biased by the round flavor; list length read at the
    // falling edge, after the checker has taken the previous transfer
    task automatic send_random(input int mode);
        int r;
        int q;
        int len;
        logic [1:0] op;
        logic [7:0] pos;
        @(negedge aclk);
        len = list_length;
        r   = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:  op = (r < 84) ? OP_INSERT : (r < 92) ? OP_PRINT :
                             (r < 98) ? OP_DELETE : OP_UNUSED;
            MODE_DRAIN: op = (r < 80) ? OP_DELETE : (r < 90) ? OP_PRINT :
                             (r < 96) ? OP_INSERT : OP_UNUSED;
            default:    op = (r < 45) ? OP_INSERT : (r < 78) ? OP_DELETE :
                             (r < 95) ? OP_PRINT : OP_UNUSED;
        endcase
        q = $urandom_range(0, 9);
        if (op == OP_INSERT) begin
            if (q < 6)       pos = 8'($urandom_range(0, len));
            else if (q == 6) pos = 8'(len);
            else if (q == 7) pos = 8'(len + 1);
            else             pos = 8'($urandom_range(0, 255));
        end else if (op == OP_DELETE) begin
            if (q < 7 && len > 0) pos = 8'($urandom_range(0, len - 1));
            else if (q < 8)       pos = 8'(len);
            else                  pos = 8'($urandom_range(0, 255));
        end else begin
            pos = 8'($urandom_range(0, 255));
        end
        send_item(op, 8'($urandom_range(0, 255)), pos);
    endtask

    initial begin
        int round;
        int n;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_INSERT;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn   = 1'b1;
        idling_on = 1'b1;

        // directed: empty list, ignored position, out of range, shifts, unused code
        send_directed(OP_PRINT,  8'h00, 8'h00);
        send_directed(OP_DELETE, 8'h00, 8'h00);
        send_directed(OP_UNUSED, 8'h00, 8'h00);
        send_directed(OP_INSERT, 8'hA5, 8'hFF);   // empty: goes to slot 0
        send_directed(OP_INSERT, 8'hFF, 8'h02);   // past the end
        send_directed(OP_INSERT, 8'h00, 8'h01);   // append
        send_directed(OP_INSERT, 8'hFF, 8'h00);   // at the head
        send_directed(OP_INSERT, 8'h5A, 8'h01);   // in the middle
        send_directed(OP_PRINT,  8'h77, 8'h40);
        send_directed(OP_DELETE, 8'h00, 8'h04);   // at length
        send_directed(OP_DELETE, 8'hFF, 8'hFF);
        send_directed(OP_INSERT, 8'h11, 8'hFF);
        send_directed(OP_DELETE, 8'h3C, 8'h01);
        send_directed(OP_DELETE, 8'h00, 8'h02);   // tail entry
        send_directed(OP_DELETE, 8'h00, 8'h00);
        send_directed(OP_PRINT,  8'h00, 8'h00);
        send_directed(OP_DELETE, 8'hC3, 8'h00);   // last entry out
        send_directed(OP_PRINT,  8'hFF, 8'hFF);
        send_directed(OP_UNUSED, 8'hFF, 8'hFF);
        send_directed(OP_DELETE, 8'h3C, 8'h80);

        // random rounds: fill, drain, mixed in turn; one quiet stretch early,
        // no idling in the last rounds
        for (round = 0; round < ROUNDS; round++) begin
            idling_on = (round != 2) && (round < ROUNDS - 2);
            for (n = 0; n < ROUND_ITEMS; n++)
                send_random(round % 3);
        end
        @(negedge aclk);
        s_tvalid = 1'b0;

        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
